// ===== src/slis_pkg.sv =====
// Package: sizes, state encoding and shared constants of the LIS length block.
`default_nettype none

package slis_pkg;

  // Tail table depth: longest length the table can track
  localparam int MAX_LEN = 256;

  // Widths, some derived from the table depth
  localparam int ADDR_W  = $clog2(MAX_LEN);
  localparam int LEN_W   = $clog2(MAX_LEN + 1);
  localparam int VALUE_W = 32;
  localparam int LIS_W   = 9;
  localparam int LIS_MAX = (1 << LIS_W) - 1;

  // Search sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROBE,
    ST_UPDATE
  } slis_state_e;

endpackage

`default_nettype wire

// ===== src/slis_if.sv =====
// Interfaces: sample input channel and length result channel.
`default_nettype none

interface slis_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [slis_pkg::VALUE_W-1:0]  sample_value;
  logic                                 last_of_sequence;

  modport source (output valid, sample_value, last_of_sequence, input ready);
  modport sink   (input valid, sample_value, last_of_sequence, output ready);
endinterface

interface slis_out_if;
  logic                         valid;
  logic                         ready;
  logic [slis_pkg::LIS_W-1:0]   lis_length;
  logic                         table_overflow;
  logic                         is_final;

  modport source (output valid, lis_length, table_overflow, is_final, input ready);
  modport sink   (input valid, lis_length, table_overflow, is_final, output ready);
endinterface

`default_nettype wire

// ===== src/slis_tail_ram.sv =====
// Single-port synchronous RAM holding the tail table, with a registered read.
`default_nettype none

module slis_tail_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 32,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             en_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    addr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, or registered read
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem[addr_i] <= wdata_i;
      end else begin
        rdata_o <= mem[addr_i];
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/strict_lis_length_stream.sv =====
// Top level: streaming longest strictly increasing subsequence length.
//
// Each sample item is resolved by a lower-bound search over the tail table,
// which lives in one single-port RAM with a registered read. The search issues
// one RAM read per cycle: the item is accepted and the first probe issued,
// then each probe result narrows the window and issues the next probe, and
// last the tail is written back and the result register loaded. The
// write-back also waits while the previous result is still unread. An empty
// table skips the probes. The result register decouples the output: the next
// item is accepted while a result still waits. After an item flagged
// last_of_sequence the length and overflow flag return to zero; no clearing
// pass is needed since only entries below the current length are ever read.
`default_nettype none

module strict_lis_length_stream (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  slis_in_if.sink   sample_i,
  slis_out_if.source result_o
);

  import slis_pkg::*;

  localparam int CMP_W = (LEN_W > LIS_W) ? LEN_W : LIS_W;

  slis_state_e st_q, st_d;

  logic signed [VALUE_W-1:0] val_q, val_d;
  logic                      last_q, last_d;
  logic [LEN_W-1:0]          lo_q, lo_d;
  logic [LEN_W-1:0]          hi_q, hi_d;
  logic [LEN_W-1:0]          mid_q, mid_d;
  logic [LEN_W-1:0]          len_q, len_d;
  logic                      ovf_q, ovf_d;

  logic                      out_valid_q, out_valid_d;
  logic [LIS_W-1:0]          out_len_q, out_len_d;
  logic                      out_ovf_q, out_ovf_d;
  logic                      out_fin_q, out_fin_d;

  // RAM port
  logic                      ram_en;
  logic                      ram_we;
  logic [ADDR_W-1:0]         ram_addr;
  logic [VALUE_W-1:0]        ram_rdata;

  // Search step
  logic                      in_fire;
  logic                      less;
  logic [LEN_W-1:0]          lo_n, hi_n, mid_n;
  logic                      more_probes;
  logic                      can_finish;
  logic                      is_append, is_drop;
  logic [LEN_W-1:0]          len_new;
  logic [CMP_W-1:0]          len_ext;

  assign in_fire     = sample_i.valid && sample_i.ready;
  assign less        = $signed(ram_rdata) < val_q;
  assign lo_n        = less ? (mid_q + LEN_W'(1)) : lo_q;
  assign hi_n        = less ? hi_q : mid_q;
  assign mid_n       = lo_n + ((hi_n - lo_n) >> 1);
  assign more_probes = lo_n < hi_n;
  assign can_finish  = !out_valid_q || result_o.ready;

  // Write-back decision at the found position
  assign is_append = (lo_q == len_q) && (len_q < LEN_W'(MAX_LEN));
  assign is_drop   = (lo_q == len_q) && (len_q == LEN_W'(MAX_LEN));
  assign len_new   = is_append ? (len_q + LEN_W'(1)) : len_q;
  assign len_ext   = CMP_W'(len_new);

  // Next state
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_IDLE: begin
        if (in_fire) begin
          st_d = (len_q != '0) ? ST_PROBE : ST_UPDATE;
        end
      end
      ST_PROBE: begin
        if (!more_probes) begin
          st_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (can_finish) begin
          st_d = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  // Outputs and datapath
  always_comb begin
    sample_i.ready = 1'b0;
    ram_en         = 1'b0;
    ram_we         = 1'b0;
    ram_addr       = mid_q[ADDR_W-1:0];
    val_d          = val_q;
    last_d         = last_q;
    lo_d           = lo_q;
    hi_d           = hi_q;
    mid_d          = mid_q;
    len_d          = len_q;
    ovf_d          = ovf_q;
    out_valid_d    = out_valid_q && !result_o.ready;
    out_len_d      = out_len_q;
    out_ovf_d      = out_ovf_q;
    out_fin_d      = out_fin_q;
    unique case (st_q)
      ST_IDLE: begin
        sample_i.ready = 1'b1;
        ram_addr       = ADDR_W'(len_q >> 1);
        if (sample_i.valid) begin
          val_d  = sample_i.sample_value;
          last_d = sample_i.last_of_sequence;
          lo_d   = '0;
          hi_d   = len_q;
          mid_d  = len_q >> 1;
          ram_en = (len_q != '0);
        end
      end
      ST_PROBE: begin
        lo_d     = lo_n;
        hi_d     = hi_n;
        mid_d    = mid_n;
        ram_addr = mid_n[ADDR_W-1:0];
        ram_en   = more_probes;
      end
      ST_UPDATE: begin
        // Replace or append the tail (a full table drops it) and load the result register
        ram_addr = lo_q[ADDR_W-1:0];
        if (can_finish) begin
          ram_en      = !is_drop;
          ram_we      = !is_drop;
          out_valid_d = 1'b1;
          out_len_d   = (len_ext > CMP_W'(LIS_MAX)) ? LIS_W'(LIS_MAX) : len_ext[LIS_W-1:0];
          out_ovf_d   = ovf_q || is_drop;
          out_fin_d   = last_q;
          if (last_q) begin
            len_d = '0;
            ovf_d = 1'b0;
          end else begin
            len_d = len_new;
            ovf_d = ovf_q || is_drop;
          end
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      len_q       <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
      lo_q        <= '0;
      hi_q        <= '0;
    end else begin
      st_q        <= st_d;
      len_q       <= len_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
      lo_q        <= lo_d;
      hi_q        <= hi_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    val_q     <= val_d;
    last_q    <= last_d;
    mid_q     <= mid_d;
    out_len_q <= out_len_d;
    out_ovf_q <= out_ovf_d;
    out_fin_q <= out_fin_d;
  end

  slis_tail_ram #(
    .DEPTH (MAX_LEN),
    .WIDTH (VALUE_W)
  ) u_tail_ram (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (val_q),
    .rdata_o (ram_rdata)
  );

  assign result_o.valid          = out_valid_q;
  assign result_o.lis_length     = out_len_q;
  assign result_o.table_overflow = out_ovf_q;
  assign result_o.is_final       = out_fin_q;

  // Checks
  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LEN_W'(MAX_LEN))
    else $error("tail count beyond table depth");

  a_probe_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_PROBE) |-> (lo_q < hi_q) && (hi_q <= len_q))
    else $error("search window empty or beyond tail count");

  a_update_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_UPDATE) |-> (lo_q <= len_q))
    else $error("found position beyond tail count");

  a_result_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_UPDATE && can_finish) |=> out_valid_q && (st_q == ST_IDLE))
    else $error("result not loaded after write-back");

endmodule

`default_nettype wire

// ===== tb/tb_strict_lis_length_stream.sv =====
// Testbench: strict_lis_length_stream checked item by item against its own LIS length predictor.
`default_nettype none

module tb_strict_lis_length_stream;
  import slis_pkg::*;

  localparam int N_DIRECTED = 24;
  localparam int N_RANDOM   = 1100;
  localparam int HOLD_OFF   = 300;

  localparam logic signed [VALUE_W-1:0] S_MIN = 32'sh8000_0000;
  localparam logic signed [VALUE_W-1:0] S_MAX = 32'sh7fff_ffff;

  // One stimulus row; len/ovf only used when typed is set
  typedef struct {
    logic signed [VALUE_W-1:0] value;
    logic                      last;
    bit                        typed;
    int                        len;
    logic                      ovf;
  } sample_row_t;

  typedef struct packed {
    logic [LIS_W-1:0] len;
    logic             ovf;
    logic             fin;
  } lis_result_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  slis_in_if  sample_ch ();
  slis_out_if result_ch ();

  strict_lis_length_stream DUT (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .sample_i (sample_ch),
    .result_o (result_ch)
  );

  // Directed rows: empty table, equal values, extremes, single-item sequence
  sample_row_t directed_rows [N_DIRECTED] = '{
    '{32'sd0,   1'b0, 1'b1, 1, 1'b0},   // first append
    '{32'sd0,   1'b0, 1'b1, 1, 1'b0},   // equal value
    '{S_MIN,    1'b0, 1'b1, 1, 1'b0},   // replaces tail
    '{S_MAX,    1'b0, 1'b1, 2, 1'b0},
    '{S_MAX,    1'b0, 1'b1, 2, 1'b0},   // equal to top tail
    '{32'sd5,   1'b0, 1'b1, 2, 1'b0},
    '{32'sd5,   1'b1, 1'b1, 2, 1'b0},   // end of sequence
    '{32'sd7,   1'b1, 1'b1, 1, 1'b0},   // one-item sequence
    '{S_MAX,    1'b0, 1'b1, 1, 1'b0},
    '{S_MIN,    1'b0, 1'b1, 1, 1'b0},
    '{-32'sd1,  1'b0, 1'b1, 2, 1'b0},
    '{32'sd0,   1'b0, 1'b1, 3, 1'b0},
    '{-32'sd1,  1'b0, 1'b0, 0, 1'b0},
    '{32'sd100, 1'b0, 1'b0, 0, 1'b0},
    '{32'sd50,  1'b0, 1'b0, 0, 1'b0},
    '{32'sd60,  1'b0, 1'b0, 0, 1'b0},
    '{32'sd10,  1'b0, 1'b0, 0, 1'b0},
    '{32'sd9,   1'b0, 1'b0, 0, 1'b0},
    '{32'sd8,   1'b0, 1'b0, 0, 1'b0},
    '{S_MIN,    1'b0, 1'b0, 0, 1'b0},
    '{S_MAX,    1'b0, 1'b0, 0, 1'b0},
    '{32'sd2,   1'b1, 1'b0, 0, 1'b0},
    '{-32'sd5,  1'b0, 1'b1, 1, 1'b0},   // fresh sequence after clear
    '{-32'sd5,  1'b1, 1'b1, 1, 1'b0}
  };

  sample_row_t stim_q [$];
  lis_result_t pending_lengths [$];
  int          n_samples_in = 0;
  int          n_bad        = 0;

  // Predictor state
  logic signed [VALUE_W-1:0] tail_model [MAX_LEN];
  int                        model_len = 0;
  logic                      model_ovf = 1'b0;

  // Clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Reset, once
  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Lower-bound search, replace or append, saturate on a full table
  function automatic lis_result_t lis_next(input logic signed [VALUE_W-1:0] v,
                                           input logic fin);
    int          lo;
    int          hi;
    int          mid;
    lis_result_t r;
    lo = 0;
    hi = model_len;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (tail_model[mid] < v) lo = mid + 1;
      else hi = mid;
    end
    if (lo < model_len) begin
      tail_model[lo] = v;
    end else if (model_len < MAX_LEN) begin
      tail_model[model_len] = v;
      model_len++;
    end else begin
      model_ovf = 1'b1;
    end
    r.len = (model_len > LIS_MAX) ? LIS_W'(LIS_MAX) : LIS_W'(model_len);
    r.ovf = model_ovf;
    r.fin = fin;
    if (fin) begin
      model_len = 0;
      model_ovf = 1'b0;
    end
    return r;
  endfunction

  task automatic push_sample(input logic signed [VALUE_W-1:0] value, input logic last);
    sample_row_t row;
    row = '{value, last, 1'b0, 0, 1'b0};
    stim_q.push_back(row);
  endtask

  // Rising run from near the bottom of the range; noisy runs mix in dips
  task automatic push_climb(input int n, input bit noisy);
    longint v;
    longint dip;
    v = longint'(S_MIN) + $urandom_range(0, 1000);
    for (int i = 0; i < n; i++) begin
      if (noisy && $urandom_range(0, 15) == 0) begin
        dip = v - $urandom_range(1, 1000);
        if (dip < longint'(S_MIN)) dip = longint'(S_MIN);
        push_sample(VALUE_W'(dip), i == n - 1);
      end else begin
        if (i != 0) v += $urandom_range(1, 10000000);
        push_sample(VALUE_W'(v), i == n - 1);
      end
    end
  endtask

  // One random sequence: full range, narrow (many equals), rising walk, or extremes
  task automatic push_sequence();
    int                        kind;
    int                        n;
    int                        w;
    logic signed [VALUE_W-1:0] v;
    kind = $urandom_range(0, 9);
    n = (kind == 7 || kind == 8) ? $urandom_range(20, 80) : $urandom_range(1, 30);
    w = int'($urandom_range(0, 200)) - 100;
    for (int i = 0; i < n; i++) begin
      case (kind)
        0, 1, 2, 3: v = $urandom();
        4, 5, 6:    v = VALUE_W'(int'($urandom_range(0, 16)) - 8);
        7, 8: begin
          if ($urandom_range(0, 5) == 0) w = w - int'($urandom_range(0, 20));
          else w = w + int'($urandom_range(0, 3));
          v = VALUE_W'(w);
        end
        default: begin
          case ($urandom_range(0, 5))
            0:       v = S_MIN;
            1:       v = S_MIN + 1;
            2:       v = S_MAX;
            3:       v = S_MAX - 1;
            4:       v = -32'sd1;
            default: v = 32'sd0;
          endcase
        end
      endcase
      push_sample(v, i == n - 1);
    end
  endtask

  // Sender: builds the stimulus, then offers it in bursts with gaps
  initial begin
    int idx;
    int n_random;
    int burst;
    int gap;
    int drain_wait;
    bit did_exact;
    bit did_over;

    sample_ch.valid            <= 1'b0;
    sample_ch.sample_value     <= '0;
    sample_ch.last_of_sequence <= 1'b0;

    for (int i = 0; i < N_DIRECTED; i++) stim_q.push_back(directed_rows[i]);
    n_random  = 0;
    did_exact = 1'b0;
    did_over  = 1'b0;
    while (n_random < N_RANDOM) begin
      if (!did_exact && n_random >= 300) begin
        push_climb(MAX_LEN, 1'b0);        // fills the table exactly
        did_exact = 1'b1;
      end else if (!did_over && n_random >= 700) begin
        push_climb(MAX_LEN + 44, 1'b1);   // runs past a full table
        did_over = 1'b1;
      end else begin
        push_sequence();
      end
      n_random = stim_q.size() - N_DIRECTED;
    end

    wait (rst_n == 1'b1);
    @(posedge clk);

    idx = 0;
    while (idx < stim_q.size()) begin
      burst = $urandom_range(1, 24);
      while (burst > 0 && idx < stim_q.size()) begin
        // After the directed rows and at the halfway point, pause until every result so far has come back
        if (idx == N_DIRECTED || idx == stim_q.size() / 2) begin
          sample_ch.valid <= 1'b0;
          do @(posedge clk); while (pending_lengths.size() != 0);
        end
        sample_ch.valid            <= 1'b1;
        sample_ch.sample_value     <= stim_q[idx].value;
        sample_ch.last_of_sequence <= stim_q[idx].last;
        do @(posedge clk); while (!sample_ch.ready);
        idx++;
        burst--;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        sample_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    sample_ch.valid <= 1'b0;

    // Drain, then keep watching for stray results
    drain_wait = 0;
    while (pending_lengths.size() != 0 && drain_wait < 20000) begin
      @(posedge clk);
      drain_wait++;
    end
    repeat (40) @(posedge clk);
    if (pending_lengths.size() != 0) begin
      n_bad++;
      $display("%0d expected results never arrived", pending_lengths.size());
    end
    if (n_bad == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Receiver: stretches of different stall patterns, plus one long hold-off
  initial begin
    int  mode;
    int  stretch;
    int  tick;
    bit  held_off;
    result_ch.ready <= 1'b0;
    tick     = 0;
    held_off = 1'b0;
    wait (rst_n == 1'b1);
    forever begin
      mode    = $urandom_range(0, 3);
      stretch = $urandom_range(16, 96);
      for (int k = 0; k < stretch; k++) begin
        @(posedge clk);
        tick++;
        if (!held_off && n_samples_in >= 500) begin
          result_ch.ready <= 1'b0;
          repeat (HOLD_OFF) @(posedge clk);
          held_off = 1'b1;
        end
        case (mode)
          0:       result_ch.ready <= 1'b1;
          1:       result_ch.ready <= $urandom_range(0, 1);
          2:       result_ch.ready <= (tick % 4) != 3;
          default: result_ch.ready <= ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end

  // Predict on each accepted item, compare each accepted result
  always @(posedge clk) begin
    lis_result_t want;
    lis_result_t got;
    if (rst_n) begin
      if (sample_ch.valid && sample_ch.ready) begin
        want = lis_next(sample_ch.sample_value, sample_ch.last_of_sequence);
        if (stim_q[n_samples_in].typed) begin
          want = '{LIS_W'(stim_q[n_samples_in].len), stim_q[n_samples_in].ovf,
                   stim_q[n_samples_in].last};
        end
        pending_lengths.push_back(want);
        n_samples_in++;
      end
      if (result_ch.valid && result_ch.ready) begin
        got = '{result_ch.lis_length, result_ch.table_overflow, result_ch.is_final};
        if (pending_lengths.size() == 0) begin
          n_bad++;
          if (n_bad <= 10)
            $display("unexpected result: len %0d ovf %0b fin %0b",
                     got.len, got.ovf, got.fin);
        end else begin
          want = pending_lengths.pop_front();
          if (got != want) begin
            n_bad++;
            if (n_bad <= 10)
              $display("mismatch: expected len %0d ovf %0b fin %0b, got len %0d ovf %0b fin %0b",
                       want.len, want.ovf, want.fin, got.len, got.ovf, got.fin);
          end
        end
      end
    end
  end

  // Hard limit on run time
  initial begin
    #3000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

`default_nettype wire
